// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the timeline queue RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/etq_pkg.sv =====
// Shared types and constants of the event timeline queue.
// No dependencies.
package etq_pkg;
  localparam int CAPACITY = 16;
  localparam int ID_BITS = 8;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_QUERY  = 3'd2,
    ACT_TIMEOF = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [ID_BITS-1:0] id;
    logic [31:0]        tv;
  } cmd_t;
endpackage

// ===== hw/rtl/etq_front.sv =====
// Front part: accepts items, drops unused action codes, masks the id,
// and queues commands for the back part. Depends on etq_pkg, assert_macros.svh.
`include "assert_macros.svh"
module etq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_action,
  input  logic [7:0]    in_event_id,
  input  logic [31:0]   in_time_value,
  output logic          q_valid,
  input  logic          q_pop,
  output etq_pkg::cmd_t q_cmd
);
  import etq_pkg::*;

  cmd_t               fifo_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, rp_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               push;
  logic               known;

  assign known    = (in_action <= ACT_CLEAR);
  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall && known;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= '{action: in_action, id: in_event_id[ID_BITS-1:0],
                        tv: in_time_value};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && !q_valid)
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > QCNT_W'(QDEPTH))
  `ASSERT_IMPL(a_unknown_dropped, clk, rst_n,
    (in_valid && !in_stall && !known && !q_pop) |=> $stable(cnt_r))
endmodule

// ===== hw/rtl/etq_back.sv =====
// Back part: the sorted cell chain and the result sequencer.
// Depends on etq_pkg, assert_macros.svh.
`include "assert_macros.svh"
module etq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  etq_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_event_id,
  output logic [31:0]   out_time,
  output logic [1:0]    out_status,
  output logic          out_last
);
  import etq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t             state_r;
  logic [31:0]        tm_r  [CAPACITY];
  logic [ID_BITS-1:0] id_r  [CAPACITY];
  logic [CAPACITY-1:0] val_r;
  logic [CNT_W-1:0]   used_r;
  logic [IDX_W-1:0]   di_r;
  logic [CNT_W-1:0]   dn_r;
  logic               ov_r;
  logic [7:0]         oid_r;
  logic [31:0]        otm_r;
  logic [1:0]         ost_r;
  logic               olast_r;

  logic [CAPACITY-1:0] hit, le, eq0;
  logic               found, full, start;
  logic [IDX_W-1:0]   fpos, ipos;
  logic [31:0]        ftime;
  logic [CNT_W-1:0]   ndue, nhit;
  logic               out_free;
  logic               load;

  assign out_free = !ov_r || !out_stall;
  assign full     = (used_r == CNT_W'(CAPACITY));

  always_comb begin
    found = 1'b0;
    fpos  = '0;
    ipos  = IDX_W'(used_r);
    ndue  = '0;
    nhit  = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      hit[k] = val_r[k] && (id_r[k] == q_cmd.id);
      le[k]  = val_r[k] && (tm_r[k] <= q_cmd.tv);
      eq0[k] = val_r[k] && (tm_r[k] == tm_r[0]);
      if (hit[k]) begin
        found = 1'b1;
        fpos  = IDX_W'(k);
      end
      if (val_r[k] && !le[k]) ipos = IDX_W'(k);
    end
    for (int k = 0; k < CAPACITY; k++) begin
      ndue = ndue + CNT_W'(eq0[k]);
      nhit = nhit + CNT_W'(hit[k]);
    end
    ftime = tm_r[fpos];
  end

  assign start = (state_r == S_IDLE) && q_valid && out_free;
  assign q_pop = start;
  assign load  = start || ((state_r == S_DRAIN) && out_free);

  always_ff @(posedge clk) begin
    if (start) begin
      case (q_cmd.action)
        ACT_INSERT: if (!found && !full) begin
          for (int k = 0; k < CAPACITY; k++) begin
            if (IDX_W'(k) > ipos && k < CAPACITY) begin
              if (k > 0) begin
                tm_r[k] <= tm_r[k-1];
                id_r[k] <= id_r[k-1];
              end
            end
          end
          tm_r[ipos] <= q_cmd.tv;
          id_r[ipos] <= q_cmd.id;
        end
        ACT_REMOVE: begin
          if (found) begin
            for (int k = 0; k < CAPACITY - 1; k++) begin
              if (IDX_W'(k) >= fpos) begin
                tm_r[k] <= tm_r[k+1];
                id_r[k] <= id_r[k+1];
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      val_r   <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
      di_r    <= '0;
      dn_r    <= '0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          case (q_cmd.action)
            ACT_INSERT: begin
              oid_r   <= 8'(q_cmd.id);
              olast_r <= 1'b1;
              if (found) begin
                otm_r <= ftime;
                ost_r <= ST_DUP;
              end else if (full) begin
                otm_r <= q_cmd.tv;
                ost_r <= ST_FULL;
              end else begin
                otm_r  <= q_cmd.tv;
                ost_r  <= ST_OK;
                val_r  <= {val_r[CAPACITY-2:0], 1'b1};
                used_r <= used_r + 1'b1;
              end
            end
            ACT_REMOVE: begin
              oid_r   <= 8'(q_cmd.id);
              olast_r <= 1'b1;
              otm_r   <= '0;
              ost_r   <= found ? ST_OK : ST_NONE;
              // ids are unique, so at most one entry goes
              if (found) begin
                val_r  <= val_r >> 1;
                used_r <= used_r - CNT_W'(nhit);
              end
            end
            ACT_QUERY: begin
              if (used_r == '0 || !le[0]) begin
                oid_r   <= '0;
                otm_r   <= q_cmd.tv;
                ost_r   <= ST_NONE;
                olast_r <= 1'b1;
              end else begin
                oid_r   <= 8'(id_r[0]);
                otm_r   <= tm_r[0];
                ost_r   <= ST_OK;
                olast_r <= (ndue == CNT_W'(1));
                di_r    <= IDX_W'(1);
                dn_r    <= ndue - 1'b1;
                if (ndue != CNT_W'(1)) state_r <= S_DRAIN;
              end
            end
            ACT_TIMEOF: begin
              oid_r   <= 8'(q_cmd.id);
              olast_r <= 1'b1;
              otm_r   <= found ? ftime : '0;
              ost_r   <= found ? ST_OK : ST_NONE;
            end
            ACT_CLEAR: begin
              oid_r   <= '0;
              olast_r <= 1'b1;
              otm_r   <= '0;
              ost_r   <= ST_OK;
              val_r   <= '0;
              used_r  <= '0;
            end
            default: ;
          endcase
        end
        S_DRAIN: if (out_free) begin
          oid_r   <= 8'(id_r[di_r]);
          ost_r   <= ST_OK;
          olast_r <= (dn_r == CNT_W'(1));
          di_r    <= di_r + 1'b1;
          dn_r    <= dn_r - 1'b1;
          if (dn_r == CNT_W'(1)) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = ov_r;
  assign out_event_id = oid_r;
  assign out_time     = otm_r;
  assign out_status   = ost_r;
  assign out_last     = olast_r;

  `ASSERT_NEVER(a_used_range, clk, rst_n, used_r > CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_prefix, clk, rst_n, 1'b1 |-> ((val_r & (val_r + 1'b1)) == '0))
  `ASSERT_NEVER(a_pop_in_drain, clk, rst_n, q_pop && (state_r == S_DRAIN))
  `ASSERT_IMPL(a_ids_unique, clk, rst_n, start |-> (nhit <= CNT_W'(1)))
endmodule

// ===== hw/rtl/event_timeline_queue.sv =====
// Top level of the event timeline queue: front queue plus back sequencer.
// Depends on etq_pkg, etq_front, etq_back.
//
// channel | ports                                   | direction
// in      | in_valid in_stall in_action in_event_id in_time_value | in
// out     | out_valid out_stall out_event_id out_time out_status out_last | out
//
// A due query emits one result per cycle while out_stall is low, one for each
// event at the earliest due time (up to 16), and takes no new item meanwhile.
// An item is written into the command queue, and its first result goes into
// the output register when the chain takes the item from the queue.
// A two-entry command queue lets the input side run ahead of the chain.
// Reset empties the table and the queue; rst_n is synchronous, active low.
// out_stall holds the output register and, through it, the chain.
module event_timeline_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_event_id,
  input  logic [31:0] in_time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_event_id,
  output logic [31:0] out_time,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import etq_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  etq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_event_id,
    .in_time_value, .q_valid, .q_pop, .q_cmd
  );

  etq_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall,
    .out_event_id, .out_time, .out_status, .out_last
  );
endmodule
